// ===== design/qpht_pkg.sv =====
package qpht_pkg;

  // Field widths of the request and response items
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned KLEN_W    = 4;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned HASH_W    = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } qpht_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } qpht_status_e;

  // Per-slot occupancy
  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_ACTIVE  = 2'd1,
    SLOT_DELETED = 2'd2
  } qpht_slot_e;

endpackage

// ===== design/qpht_req_if.sv =====
interface qpht_req_if import qpht_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [KEY_W-1:0]     key_bytes;
  logic [KLEN_W-1:0]    key_length;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, action, key_bytes, key_length, payload, input ready);
  modport sink   (input valid, action, key_bytes, key_length, payload, output ready);
endinterface

// ===== design/qpht_rsp_if.sv =====
interface qpht_rsp_if import qpht_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 found;
  logic [PAYLOAD_W-1:0] found_payload;
  logic [SLOT_W-1:0]    slot;
  logic [COUNT_W-1:0]   entry_count;

  modport source (output valid, status, found, found_payload, slot, entry_count, input ready);
  modport sink   (input valid, status, found, found_payload, slot, entry_count, output ready);
endinterface

// ===== design/qpht_hash.sv =====
module qpht_hash import qpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1021
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [KEY_W-1:0]              key_i,
  input  logic [KLEN_W-1:0]             len_i,
  output logic                          done_o,
  output logic [$clog2(TABLE_SIZE)-1:0] home_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam int unsigned R_W   = IDX_W + 1;
  localparam int unsigned SHIFT = HASH_W - 1 + IDX_W;
  localparam logic [R_W-1:0] MOD_R = R_W'(TABLE_SIZE);
  // floor(2^SHIFT / TABLE_SIZE): the quotient estimate is exact or one short
  localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << SHIFT) / 64'(TABLE_SIZE));

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_ACC  = 3'd1;
  localparam logic [2:0] H_MUL  = 3'd2;
  localparam logic [2:0] H_SUB  = 3'd3;
  localparam logic [2:0] H_FIX  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [HASH_W-1:0]   h_q, h_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [KLEN_W-1:0]   len_q, len_d;
  logic [KLEN_W-1:0]   idx_q, idx_d;
  logic                neg_q, neg_d;
  logic [2*HASH_W-1:0] prod_q, prod_d;
  logic [R_W-1:0]      r_q, r_d;
  logic                done_q, done_d;
  logic [IDX_W-1:0]    home_q, home_d;

  logic [7:0]          cur_byte;
  logic [HASH_W-1:0]   quot;
  logic [HASH_W-1:0]   rem_full;
  logic [IDX_W-1:0]    r_fix;

  assign cur_byte = key_q[{idx_q[2:0], 3'b000} +: 8];

  // What is left after the estimated quotient stays below twice the table size
  assign quot     = HASH_W'(prod_q >> SHIFT);
  assign rem_full = h_q - HASH_W'(quot * HASH_W'(TABLE_SIZE));
  assign r_fix    = (r_q >= MOD_R) ? IDX_W'(r_q - MOD_R) : r_q[IDX_W-1:0];

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    key_d   = key_q;
    len_d   = len_q;
    idx_d   = idx_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    r_d     = r_q;
    done_d  = 1'b0;
    home_d  = home_q;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          len_d   = len_i;
          idx_d   = '0;
          h_d     = '0;
          state_d = H_ACC;
        end
      end
      H_ACC: begin
        if (idx_q == len_q) begin
          // Take the magnitude; the sign is folded back in at the end
          neg_d   = h_q[HASH_W-1];
          h_d     = h_q[HASH_W-1] ? (HASH_W'(0) - h_q) : h_q;
          state_d = H_MUL;
        end else begin
          h_d   = HASH_W'(h_q * HASH_W'(37)) + {{(HASH_W-8){cur_byte[7]}}, cur_byte};
          idx_d = idx_q + KLEN_W'(1);
        end
      end
      H_MUL: begin
        prod_d  = (2*HASH_W)'(h_q) * (2*HASH_W)'(RECIP);
        state_d = H_SUB;
      end
      H_SUB: begin
        r_d     = rem_full[R_W-1:0];
        state_d = H_FIX;
      end
      H_FIX: begin
        if (neg_q && (r_fix != '0)) begin
          home_d = IDX_W'(MOD_R - {1'b0, r_fix});
        end else begin
          home_d = r_fix;
        end
        done_d  = 1'b1;
        state_d = H_IDLE;
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    key_q  <= key_d;
    len_q  <= len_d;
    idx_q  <= idx_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    r_q    <= r_d;
    home_q <= home_d;
  end

  assign done_o = done_q;
  assign home_o = home_q;

endmodule

// ===== design/quadratic_probe_hash_table.sv =====
// Channel  Modport             Item
// req_i    qpht_req_if.sink    action, key_bytes, key_length, payload
// rsp_o    qpht_rsp_if.source  status, found, found_payload, slot, entry_count
//
// Insert/remove/find hash the saturated key, then probe slots until a stop or the probe cap.
// The hash takes one key byte a cycle, then multiply, subtract and fix steps reduce it
// modulo TABLE_SIZE by a reciprocal multiply; probing reads one slot a cycle from the
// slot memory. Clear sweeps every slot to empty; after reset the same sweep runs with
// req_i.ready low.
// One request at a time; the next is taken while the previous response waits.
module quadratic_probe_hash_table import qpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1021,
  parameter int unsigned KEY_CHARS  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qpht_req_if.sink   req_i,
  qpht_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned I_W    = $clog2(TABLE_SIZE + 1);
  localparam int unsigned HALF   = TABLE_SIZE / 2;
  localparam int unsigned CNT_W  = $clog2(HALF + 1);
  localparam int unsigned SKEY_W = 8 * KEY_CHARS;
  localparam logic [IDX_W:0] MOD_P = (IDX_W+1)'(TABLE_SIZE);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  typedef struct packed {
    qpht_slot_e            state;
    logic [KLEN_W-1:0]     len;
    logic [SKEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0]  payload;
  } entry_t;

  typedef struct packed {
    qpht_status_e          status;
    logic                  found;
    logic [PAYLOAD_W-1:0]  payload;
    logic [IDX_W-1:0]      pos;
    logic [CNT_W-1:0]      count;
  } result_t;

  entry_t mem_q [TABLE_SIZE];
  entry_t rd_q;

  logic [2:0]           state_q, state_d;
  qpht_action_e         action_q, action_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [KLEN_W-1:0]    len_q, len_d;
  logic [PAYLOAD_W-1:0] pay_q, pay_d;
  logic                 clr_rsp_q, clr_rsp_d;
  logic [IDX_W-1:0]     sweep_q, sweep_d;
  logic [IDX_W-1:0]     p_q, p_d;
  logic [IDX_W-1:0]     inc_q, inc_d;
  logic [I_W-1:0]       i_q, i_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  result_t              res_q, res_d;
  logic                 out_vld_q, out_vld_d;
  result_t              out_q, out_d;

  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_addr;
  entry_t               mem_wdata;

  logic                 hash_start, hash_done;
  logic [IDX_W-1:0]     hash_home;

  logic [KLEN_W-1:0]    len_sat;
  logic [KEY_W-1:0]     key_mask;
  logic [IDX_W:0]       p_sum, inc_sum;
  logic [IDX_W-1:0]     p_next, inc_next;
  logic                 stop, act, last_probe;

  qpht_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_mask),
    .len_i   (len_sat),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  // Saturate the length and zero the bytes past it
  always_comb begin
    len_sat = (req_i.key_length > KLEN_W'(KEY_CHARS)) ? KLEN_W'(KEY_CHARS) : req_i.key_length;
    for (int b = 0; b < KEY_W / 8; b++) begin
      key_mask[8*b +: 8] = (KLEN_W'(b) < len_sat) ? req_i.key_bytes[8*b +: 8] : 8'h00;
    end
  end

  // Next probe position: p + (2i-1), increment kept reduced
  assign p_sum    = {1'b0, p_q} + {1'b0, inc_q};
  assign p_next   = (p_sum >= MOD_P) ? IDX_W'(p_sum - MOD_P) : p_sum[IDX_W-1:0];
  assign inc_sum  = {1'b0, inc_q} + (IDX_W+1)'(2);
  assign inc_next = (inc_sum >= MOD_P) ? IDX_W'(inc_sum - MOD_P) : inc_sum[IDX_W-1:0];

  assign stop = (rd_q.state == SLOT_EMPTY) ||
                ((rd_q.len == len_q) && (rd_q.key == key_q[SKEY_W-1:0]));
  assign act  = stop && (rd_q.state == SLOT_ACTIVE);
  assign last_probe = (i_q == I_W'(TABLE_SIZE));

  assign req_i.ready = (state_q == S_IDLE);
  assign hash_start  = (state_q == S_IDLE) && req_i.valid && (req_i.action != ACT_CLEAR);

  always_comb begin
    state_d   = state_q;
    action_d  = action_q;
    key_d     = key_q;
    len_d     = len_q;
    pay_d     = pay_q;
    clr_rsp_d = clr_rsp_q;
    sweep_d   = sweep_q;
    p_d       = p_q;
    inc_d     = inc_q;
    i_d       = i_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = p_q;
    mem_wdata = rd_q;

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        mem_we          = 1'b1;
        mem_addr        = sweep_q;
        mem_wdata       = '0;
        mem_wdata.state = SLOT_EMPTY;
        sweep_d         = sweep_q + IDX_W'(1);
        if (sweep_q == IDX_W'(TABLE_SIZE - 1)) begin
          cnt_d = '0;
          res_d = '{status: ST_OK, found: 1'b0, payload: '0, pos: '0, count: '0};
          // Reset sweep has no request to answer
          state_d = clr_rsp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          action_d = qpht_action_e'(req_i.action);
          key_d    = key_mask;
          len_d    = len_sat;
          pay_d    = req_i.payload;
          if (req_i.action == ACT_CLEAR) begin
            clr_rsp_d = 1'b1;
            sweep_d   = '0;
            state_d   = S_CLR;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          mem_re   = 1'b1;
          mem_addr = hash_home;
          p_d      = hash_home;
          inc_d    = IDX_W'(1);
          i_d      = I_W'(1);
          state_d  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stop && !last_probe) begin
          mem_re   = 1'b1;
          mem_addr = p_next;
          p_d      = p_next;
          inc_d    = inc_next;
          i_d      = i_q + I_W'(1);
        end else begin
          res_d.found   = act;
          res_d.payload = act ? rd_q.payload : '0;
          res_d.pos     = p_q;
          res_d.status  = ST_OK;
          unique case (action_q)
            ACT_INSERT: begin
              if (act) begin
                res_d.status = ST_PRESENT;
              end else if (!stop || (cnt_q >= CNT_W'(HALF))) begin
                res_d.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = '{state: SLOT_ACTIVE, len: len_q, key: key_q[SKEY_W-1:0],
                              payload: pay_q};
                cnt_d     = cnt_q + CNT_W'(1);
              end
            end
            ACT_REMOVE: begin
              if (act) begin
                mem_we          = 1'b1;
                mem_wdata.state = SLOT_DELETED;
                cnt_d           = cnt_q - CNT_W'(1);
              end else begin
                res_d.status = ST_NOT_FOUND;
              end
            end
            ACT_FIND: begin
              if (!act) begin
                res_d.status = ST_NOT_FOUND;
              end
            end
            default: res_d.status = ST_OK;
          endcase
          res_d.count = cnt_d;
          state_d     = S_RESP;
        end
      end
      S_RESP: begin
        // Hold until the output register is free
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_rsp_q <= 1'b0;
      sweep_q   <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_rsp_q <= clr_rsp_d;
      sweep_q   <= sweep_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    key_q    <= key_d;
    len_q    <= len_d;
    pay_q    <= pay_d;
    p_q      <= p_d;
    inc_q    <= inc_d;
    i_q      <= i_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.found         = out_q.found;
  assign rsp_o.found_payload = out_q.payload;
  assign rsp_o.slot          = SLOT_W'(out_q.pos);
  assign rsp_o.entry_count   = COUNT_W'(out_q.count);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(HALF))
    else $error("active count above half the table");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("slot memory read and written in one cycle");

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> ((i_q <= I_W'(TABLE_SIZE)) && ({1'b0, p_q} < MOD_P)
                             && ({1'b0, inc_q} < MOD_P)))
    else $error("probe position or step out of range");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && mem_we && action_q == ACT_INSERT) |=>
      (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("insert did not bump the count");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_vld_q && !rsp_o.ready) |=> (state_q == S_RESP))
    else $error("pending response overwritten");

endmodule

// ===== tb/qpht_checker.sv =====
module qpht_checker import qpht_pkg::*; #(
  parameter int unsigned TABLE_SIZE = 1021,
  parameter int unsigned KEY_CHARS  = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  qpht_req_if  req_mon,
  qpht_rsp_if  rsp_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    qpht_status_e         status;
    logic                 found;
    logic [PAYLOAD_W-1:0] fpay;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   count;
  } hash_rsp_t;

  logic [KEY_W-1:0]     tbl_key   [TABLE_SIZE];
  logic [KLEN_W-1:0]    tbl_len   [TABLE_SIZE];
  logic [PAYLOAD_W-1:0] tbl_pay   [TABLE_SIZE];
  qpht_slot_e           tbl_state [TABLE_SIZE];
  int unsigned          live_cnt;

  hash_rsp_t rsp_due_q[$];
  int        fails;
  int        n_checked;

  assign fail_cnt_o = fails;

  function automatic int unsigned home_slot(logic [KEY_W-1:0] key, int unsigned klen);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] rem;
    h = '0;
    for (int unsigned i = 0; i < klen; i++) begin
      h = h * 32'd37 + {{24{key[8*i+7]}}, key[8*i +: 8]};
    end
    // negative hash: signed remainder, then move into range
    if (h[HASH_W-1]) begin
      rem = (32'd0 - h) % TABLE_SIZE;
      return (rem == 0) ? 0 : TABLE_SIZE - rem;
    end
    return h % TABLE_SIZE;
  endfunction

  function automatic hash_rsp_t hash_table_update(qpht_action_e act, logic [KEY_W-1:0] raw_key,
                                                  logic [KLEN_W-1:0] raw_len,
                                                  logic [PAYLOAD_W-1:0] pay);
    hash_rsp_t   r;
    logic [KEY_W-1:0] key;
    int unsigned klen;
    int unsigned pos;
    logic        stopped;
    logic        hit;
    r = '0;
    r.status = ST_OK;
    klen = (raw_len > KEY_CHARS) ? KEY_CHARS : raw_len;
    key = raw_key;
    if (klen < 8) key &= (64'd1 << (8 * klen)) - 64'd1;

    if (act == ACT_CLEAR) begin
      foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
      live_cnt = 0;
    end else begin
      pos = home_slot(key, klen);
      stopped = 1'b0;
      for (int unsigned step = 1; step <= TABLE_SIZE; step++) begin
        if (tbl_state[pos] == SLOT_EMPTY || (tbl_len[pos] == klen && tbl_key[pos] == key)) begin
          stopped = 1'b1;
          break;
        end
        if (step == TABLE_SIZE) break;
        pos = (pos + 2 * step - 1) % TABLE_SIZE;
      end
      hit = stopped && tbl_state[pos] == SLOT_ACTIVE;
      if (hit) begin
        r.found = 1'b1;
        r.fpay  = tbl_pay[pos];
      end
      case (act)
        ACT_INSERT: begin
          if (hit) begin
            r.status = ST_PRESENT;
          end else if (!stopped || live_cnt + 1 > TABLE_SIZE / 2) begin
            r.status = ST_FULL;
          end else begin
            tbl_key[pos]   = key;
            tbl_len[pos]   = klen[KLEN_W-1:0];
            tbl_pay[pos]   = pay;
            tbl_state[pos] = SLOT_ACTIVE;
            live_cnt++;
          end
        end
        ACT_REMOVE: begin
          if (hit) begin
            tbl_state[pos] = SLOT_DELETED;
            live_cnt--;
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        default: begin
          if (!hit) r.status = ST_NOT_FOUND;
        end
      endcase
      r.slot = pos[SLOT_W-1:0];
    end
    r.count = live_cnt[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hash_rsp_t want;
    if (!rst_ni) begin
      foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
      live_cnt = 0;
      rsp_due_q.delete();
      fails = 0;
      n_checked = 0;
      pending_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (rsp_due_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("Unexpected response: status=%0d found=%0b payload=%h slot=%0d count=%0d",
                     rsp_mon.status, rsp_mon.found, rsp_mon.found_payload, rsp_mon.slot,
                     rsp_mon.entry_count);
          end
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp_mon.status !== want.status || rsp_mon.found !== want.found ||
              rsp_mon.found_payload !== want.fpay || rsp_mon.slot !== want.slot ||
              rsp_mon.entry_count !== want.count) begin
            fails++;
            if (fails <= 10) begin
              $display("Response %0d mismatch:", n_checked);
              $display("  expected status=%0d found=%0b payload=%h slot=%0d count=%0d",
                       want.status, want.found, want.fpay, want.slot, want.count);
              $display("  got      status=%0d found=%0b payload=%h slot=%0d count=%0d",
                       rsp_mon.status, rsp_mon.found, rsp_mon.found_payload, rsp_mon.slot,
                       rsp_mon.entry_count);
            end
          end
        end
        n_checked++;
      end
      if (req_mon.valid && req_mon.ready) begin
        want = hash_table_update(qpht_action_e'(req_mon.action), req_mon.key_bytes,
                                 req_mon.key_length, req_mon.payload);
        rsp_due_q = {rsp_due_q, want};
      end
      pending_o <= rsp_due_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
module tb import qpht_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SIZE = 1021;
  localparam int unsigned KEY_CHARS  = 8;
  localparam int unsigned HALF       = TABLE_SIZE / 2;
  localparam int unsigned RAND_ITEMS = 760;
  localparam int unsigned POOL_N     = 48;
  localparam int unsigned FILL_N     = HALF + 3;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  qpht_req_if req_if ();
  qpht_rsp_if rsp_if ();

  int fail_cnt;
  int pending;

  int unsigned n_sent;
  int unsigned rsp_taken;
  int unsigned n_act [4];

  logic [KEY_W-1:0] pool_key [POOL_N];
  int unsigned      pool_len [POOL_N];
  logic [23:0]      fill_key [FILL_N];

  quadratic_probe_hash_table #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_CHARS  (KEY_CHARS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  qpht_checker #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_CHARS  (KEY_CHARS)
  ) u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send_req(input qpht_action_e act, input logic [KEY_W-1:0] key,
                          input logic [KLEN_W-1:0] klen, input logic [PAYLOAD_W-1:0] pay);
    // no idling inside one stretch of items
    while (!(n_sent >= 400 && n_sent < 600) && $urandom_range(99) < 7) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.key_bytes  <= key;
    req_if.key_length <= klen;
    req_if.payload    <= pay;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
    n_act[act]++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // response side: random stalls, one long hold-off, one stall-free stretch
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    rsp_taken = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) rsp_taken++;
      if (!hold_done && rsp_taken >= 80) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        rsp_if.ready <= (rsp_taken >= 500 && rsp_taken < 700) || $urandom_range(99) >= 7;
      end
    end
  end

  initial begin
    #(12_000_000);
    $display("Timeout: responses still outstanding");
    $display("Verification failed");
    $finish;
  end

  initial begin
    int               tsz;
    int               target;
    int               res;
    int               s2;
    int unsigned      n;
    int unsigned      pick;
    int unsigned      roll;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] noise;
    logic [KEY_W-1:0] mask;
    logic [KLEN_W-1:0] klen;
    qpht_action_e     act;

    n_sent = 0;
    foreach (n_act[i]) n_act[i] = 0;
    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_FIND;
    req_if.key_bytes  <= '0;
    req_if.key_length <= '0;
    req_if.payload    <= '0;

    foreach (pool_key[i]) begin
      pool_key[i] = {$urandom, $urandom};
      pool_len[i] = $urandom_range(8);
    end

    // 3-byte keys that all hash to one home slot: h = 37*37*b0 + 37*b1 + b2
    tsz = int'(TABLE_SIZE);
    target = $urandom_range(TABLE_SIZE - 1);
    n = 0;
    for (int s0 = -128; s0 < 128 && n < FILL_N; s0++) begin
      for (int s1 = -128; s1 < 128 && n < FILL_N; s1++) begin
        res = ((target - 37 * 37 * s0 - 37 * s1) % tsz + tsz) % tsz;
        if (res <= 127) s2 = res;
        else if (res >= tsz - 128) s2 = res - tsz;
        else continue;
        fill_key[n] = {s2[7:0], s1[7:0], s0[7:0]};
        n++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty key, saturated length, signed bytes, tombstones, clear
    send_req(ACT_FIND,   64'h0, 4'd0, 32'h0);
    send_req(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'hFFFF_FFFF);
    send_req(ACT_INSERT, 64'h0, 4'd0, 32'h0);
    send_req(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0);
    send_req(ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(ACT_INSERT, 64'h0123_4567_8080_8080, 4'd4, 32'h8000_0001);
    send_req(ACT_FIND,   64'hFEDC_BA98_8080_8080, 4'd4, 32'hFFFF_FFFF);
    send_req(ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h0);
    send_req(ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'h1234_5678);
    send_req(ACT_FIND,   64'h0, 4'd8, 32'h0);
    send_req(ACT_INSERT, 64'h0, 4'd8, 32'h5555_AAAA);
    send_req(ACT_REMOVE, 64'h0, 4'd0, 32'h0);
    send_req(ACT_FIND,   64'h0, 4'd8, 32'h0);
    send_req(ACT_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 4'd8, 32'hAAAA_5555);
    send_req(ACT_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
    send_req(ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
    send_req(ACT_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 4'd8, 32'h0F0F_F0F0);
    send_req(ACT_REMOVE, 64'h7F7F_7F7F_7F7F_7F7F, 4'd7, 32'h0);
    wait_drained();

    // random traffic over a small key pool, with fresh keys as noise
    for (int unsigned it = 0; it < RAND_ITEMS; it++) begin
      roll = $urandom_range(99);
      if (roll < 2) act = ACT_CLEAR;
      else if (roll < 42) act = ACT_INSERT;
      else if (roll < 65) act = ACT_REMOVE;
      else act = ACT_FIND;
      noise = {$urandom, $urandom};
      if ($urandom_range(99) < 15) begin
        key  = noise;
        klen = KLEN_W'($urandom_range(15));
      end else begin
        pick = $urandom_range(POOL_N - 1);
        mask = (pool_len[pick] >= 8) ? '1 : (64'd1 << (8 * pool_len[pick])) - 64'd1;
        key  = (pool_key[pick] & mask) | (noise & ~mask);
        klen = (pool_len[pick] >= 8) ? KLEN_W'($urandom_range(15, 8))
                                     : KLEN_W'(pool_len[pick]);
      end
      send_req(act, key, klen, $urandom);
    end

    // fill one probe sequence: load limit, tombstones, then the probe cap
    send_req(ACT_CLEAR, {$urandom, $urandom}, KLEN_W'($urandom_range(15)), $urandom);
    for (int unsigned j = 0; j < HALF; j++) begin
      noise = {$urandom, $urandom};
      send_req(ACT_INSERT, {noise[63:24], fill_key[j]}, 4'd3, $urandom);
    end
    noise = {$urandom, $urandom};
    send_req(ACT_INSERT, {noise[63:24], fill_key[HALF]},     4'd3, $urandom);
    send_req(ACT_REMOVE, {noise[63:24], fill_key[0]},        4'd3, $urandom);
    send_req(ACT_INSERT, {noise[63:24], fill_key[HALF + 1]}, 4'd3, $urandom);
    send_req(ACT_REMOVE, {noise[63:24], fill_key[1]},        4'd3, $urandom);
    send_req(ACT_FIND,   {noise[63:24], fill_key[HALF + 2]}, 4'd3, $urandom);
    send_req(ACT_INSERT, {noise[63:24], fill_key[HALF + 2]}, 4'd3, $urandom);
    send_req(ACT_REMOVE, {noise[63:24], fill_key[HALF + 2]}, 4'd3, $urandom);
    send_req(ACT_INSERT, {noise[63:24], fill_key[0]},        4'd3, $urandom);
    send_req(ACT_FIND,   {noise[63:24], fill_key[1]},        4'd3, $urandom);
    send_req(ACT_FIND,   {noise[63:24], fill_key[HALF / 2]}, 4'd3, $urandom);
    send_req(ACT_CLEAR,  {noise[63:24], fill_key[2]},        4'd3, $urandom);

    wait_drained();
    repeat (60) @(posedge clk_i);

    $display("Sent %0d requests: %0d insert, %0d remove, %0d find, %0d clear; %0d responses",
             n_sent, n_act[ACT_INSERT], n_act[ACT_REMOVE], n_act[ACT_FIND], n_act[ACT_CLEAR],
             rsp_taken);
    $display("Covered length saturation, tombstone reuse, the load limit and a capped probe");
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
